/* src/ts_payload_extractor_macros.svh */
// Assertion macros shared by the transport stream payload extractor RTL.
`ifndef TS_PAYLOAD_EXTRACTOR_MACROS_SVH
`define TS_PAYLOAD_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge outside reset.
`define TSPE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Implication property checked at every clock edge outside reset.
`define TSPE_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`else

`define TSPE_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TSPE_ASSERT_IMPL(label, clk, rst_n, prop)

`endif

`endif

/* src/tspe_pkg.sv */
// Types and constants of the transport stream payload extractor.
`default_nettype none

package tspe_pkg;

  localparam int BYTE_W    = 8;
  localparam int PID_W     = 13;
  localparam int START_W   = 9;   // payload start can reach 5 + 255
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'h47;
  localparam int                FLAG_PAYLOAD_BIT = 4;  // 0x10
  localparam int                FLAG_ADAPT_BIT   = 5;  // 0x20
  localparam int                PID_HI_BITS      = 5;  // low 5 bits of header byte 1

  // Header byte positions
  localparam int POS_PID_HI    = 1;
  localparam int POS_PID_LO    = 2;
  localparam int POS_FLAGS     = 3;
  localparam int POS_ADAPT_LEN = 4;
  localparam int HDR_BYTES     = 4;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WANTED_PID = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              first_of_payload;
    logic              last_of_payload;
    logic              sync_error;
  } tspe_result_t;

endpackage

`default_nettype wire

/* src/tspe_cfg.sv */
// APB-style register file holding the wanted PID.
`default_nettype none

module tspe_cfg import tspe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [PID_W-1:0]      wanted_pid
);

  logic [PID_W-1:0]     wanted_pid_r;
  logic [PID_W-1:0]     wanted_pid_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    wanted_pid_nxt = wanted_pid_r;
    if (wr_en) begin
      case (reg_idx)
        REG_WANTED_PID: wanted_pid_nxt = pwdata[PID_W-1:0];
        default:        wanted_pid_nxt = wanted_pid_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WANTED_PID: prdata = {{(APB_DATA_W-PID_W){1'b0}}, wanted_pid_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_pid_r <= '0;
    end else begin
      wanted_pid_r <= wanted_pid_nxt;
    end
  end

  assign wanted_pid = wanted_pid_r;

endmodule

`default_nettype wire

/* src/tspe_parser.sv */
// Packet header parser: position count, PID match and payload selection.
`default_nettype none

`include "ts_payload_extractor_macros.svh"

module tspe_parser import tspe_pkg::*; #(
  parameter int PACKET_BYTES = 188
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] stream_byte,
  input  wire logic [PID_W-1:0]  wanted_pid,
  output logic                   emit,
  output tspe_result_t           res
);

  localparam int               POS_W    = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
  localparam logic [START_W-1:0] PKT_LEN = START_W'(PACKET_BYTES);

  logic [POS_W-1:0]   pos_r,     pos_nxt;
  logic [PID_W-1:0]   pid_r,     pid_nxt;
  logic               good_r,    good_nxt;
  logic               adapt_r,   adapt_nxt;
  logic [START_W-1:0] start_r,   start_nxt;
  logic [PID_W-1:0]   latched_r, latched_nxt;
  logic [PID_W-1:0]   want;
  logic               sync_err;

  assign want = (wanted_pid != '0) ? wanted_pid : latched_r;

  always_comb begin
    pid_nxt     = pid_r;
    good_nxt    = good_r;
    adapt_nxt   = adapt_r;
    start_nxt   = start_r;
    latched_nxt = latched_r;
    sync_err    = 1'b0;

    if (pos_r == '0) begin
      good_nxt = (stream_byte == SYNC_BYTE);
      sync_err = (stream_byte != SYNC_BYTE);
    end else if (pos_r == POS_W'(POS_PID_HI)) begin
      pid_nxt = {stream_byte[PID_HI_BITS-1:0], {BYTE_W{1'b0}}};
    end else if (pos_r == POS_W'(POS_PID_LO)) begin
      pid_nxt = pid_r | {{(PID_W-BYTE_W){1'b0}}, stream_byte};
    end else if (pos_r == POS_W'(POS_FLAGS)) begin
      adapt_nxt = stream_byte[FLAG_ADAPT_BIT];
      start_nxt = START_W'(HDR_BYTES);
      if (good_r) begin
        if (!stream_byte[FLAG_PAYLOAD_BIT]) begin
          good_nxt = 1'b0;
        end else if (want == '0) begin
          latched_nxt = pid_r;          // zero PID leaves it unset
        end else if (want != pid_r) begin
          good_nxt = 1'b0;
        end
      end
    end else if (pos_r == POS_W'(POS_ADAPT_LEN) && adapt_r) begin
      start_nxt = START_W'(POS_ADAPT_LEN + 1) + {1'b0, stream_byte};
      if (start_nxt >= PKT_LEN) begin
        good_nxt = 1'b0;
      end
    end

    pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
  end

  // Result for the byte in hand
  always_comb begin
    res  = '0;
    emit = 1'b0;
    if (sync_err) begin
      emit           = 1'b1;
      res.sync_error = 1'b1;
    end else if (pos_r >= POS_W'(HDR_BYTES) && good_nxt &&
                 START_W'(pos_r) >= start_nxt) begin
      emit                 = 1'b1;
      res.payload_byte     = stream_byte;
      res.first_of_payload = (START_W'(pos_r) == start_nxt);
      res.last_of_payload  = (pos_r == LAST_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      pid_r     <= '0;
      good_r    <= 1'b0;
      adapt_r   <= 1'b0;
      start_r   <= START_W'(HDR_BYTES);
      latched_r <= '0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      pid_r     <= pid_nxt;
      good_r    <= good_nxt;
      adapt_r   <= adapt_nxt;
      start_r   <= start_nxt;
      latched_r <= latched_nxt;
    end
  end

  `TSPE_ASSERT_IMPL(a_pos_wrap, clk, rst_n, (step && pos_r == LAST_POS) |=> (pos_r == '0))
  `TSPE_ASSERT_ALWAYS(a_pos_range, clk, rst_n, pos_r <= LAST_POS)
  `TSPE_ASSERT_IMPL(a_first_after_hdr, clk, rst_n,
    (step && emit && res.first_of_payload) |-> (pos_r >= POS_W'(HDR_BYTES)))

endmodule

`default_nettype wire

/* src/tspe_out_reg.sv */
// Result register with valid/ready handshake toward the receiver.
`default_nettype none

module tspe_out_reg import tspe_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire tspe_result_t res_in,
  input  wire logic         out_ready,
  output logic              can_take,
  output logic              out_valid,
  output tspe_result_t      res_out
);

  logic         valid_r, valid_nxt;
  tspe_result_t res_r;

  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

/* src/ts_payload_extractor.sv */
// Top level of the transport stream payload extractor.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_stream_byte): one beat per byte of a
//    packet-aligned transport stream; the first beat after reset is byte 0 of
//    a packet of PACKET_BYTES bytes.
//  - Result channel (out_valid/out_ready/out_*): one beat per payload byte of
//    packets whose PID matches, first/last marked; a packet whose first byte
//    is not 0x47 gives a single beat with out_sync_error set and nothing else.
//  - APB port: register 0 (address 0) is wanted_pid; zero latches the PID of
//    the first packet that carries a payload. Write only while idle.
// Timing:
//  - Path: an accepted byte passes the input register, then header logic into
//    the result register; out_valid rises once the result register is loaded.
//  - Throughput: one byte per cycle unless out_ready stalls; the input and result
//    registers each hold one beat, so one more byte is taken while a result waits.
// Reset (synchronous, rst_n low): position back to byte 0, wanted and latched
// PID cleared, both registers emptied.
// Stall: with out_ready low the result register holds its beat; one more byte
// is taken into the input register, then in_ready drops until the result moves.
`default_nettype none

`include "ts_payload_extractor_macros.svh"

module ts_payload_extractor import tspe_pkg::*; #(
  parameter int PACKET_BYTES = 188
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // stream input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_stream_byte,
  // results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [BYTE_W-1:0]     out_payload_byte,
  output logic                       out_first_of_payload,
  output logic                       out_last_of_payload,
  output logic                       out_sync_error,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              process_en;
  logic              can_take;
  logic              emit;
  logic [PID_W-1:0]  wanted_pid;
  tspe_result_t      res;
  tspe_result_t      res_out;

  tspe_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .wanted_pid (wanted_pid)
  );

  // Byte in the input register is consumed once the result side has room,
  // whether or not it yields a result.
  assign process_en = s1_valid_r && can_take;
  assign in_ready   = !s1_valid_r || process_en;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (process_en) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_stream_byte;
    end
  end

  tspe_parser #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (process_en),
    .stream_byte (s1_byte_r),
    .wanted_pid  (wanted_pid),
    .emit        (emit),
    .res         (res)
  );

  tspe_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (process_en && emit),
    .res_in    (res),
    .out_ready (out_ready),
    .can_take  (can_take),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_payload_byte     = res_out.payload_byte;
  assign out_first_of_payload = res_out.first_of_payload;
  assign out_last_of_payload  = res_out.last_of_payload;
  assign out_sync_error       = res_out.sync_error;

  `TSPE_ASSERT_ALWAYS(a_empty_takes, clk, rst_n, s1_valid_r || in_ready)
  `TSPE_ASSERT_IMPL(a_s1_hold, clk, rst_n,
    (s1_valid_r && !process_en) |=> (s1_valid_r && $stable(s1_byte_r)))
  `TSPE_ASSERT_IMPL(a_err_beat_clean, clk, rst_n,
    (out_valid && out_sync_error) |-> (out_payload_byte == '0 &&
      !out_first_of_payload && !out_last_of_payload))

endmodule

`default_nettype wire
